[hdl/attractor_ds_velocity_with_force_pi_defines.svh]
// Assertion macros used by the block that checks its own logic.
`ifndef ATTRACTOR_DS_VELOCITY_WITH_FORCE_PI_DEFINES_SVH
`define ATTRACTOR_DS_VELOCITY_WITH_FORCE_PI_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define ADSV_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adsv check failed");

// Next-cycle implication, checked outside reset.
`define ADSV_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adsv check failed");

`endif

[hdl/adsv_pkg.sv]
package adsv_pkg;

  // Control tick rate and PI enable
  localparam int unsigned LOOP_RATE_HZ = 500;
  localparam bit          PI_ENABLED   = 1'b1;

  // Contact threshold (0.02) and low clamp (-0.3), Q16.16
  localparam int                 CONTACT_TH    = 1311;
  localparam logic [21:0]        CONTACT_TH_SQ = 22'(CONTACT_TH * CONTACT_TH);
  localparam logic signed [31:0] LOW_CLAMP     = -32'sd19661;

  // Serial unit step counts
  localparam int CNT_W      = 7;
  localparam int MUL_STEPS  = 32;
  localparam int DIV_STEPS  = 64;
  localparam int ROOT_STEPS = 32;

  typedef enum logic [2:0] {
    REG_GAIN, REG_LIMIT, REG_OFF_X, REG_OFF_Y, REG_OFF_Z, REG_KP, REG_KI, REG_TARGET
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SQ_E, ST_PI_INT, ST_PI_P, ST_PI_I, ST_V_MUL, ST_V_SQ, ST_LIM_SQ,
    ST_ROOT, ST_SC_MUL, ST_SC_DIV, ST_NP_DIV, ST_DONE
  } state_t;

  typedef enum logic [1:0] {OP_NONE, OP_MUL, OP_DIV, OP_ROOT} op_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [31:0] goal_vel_x;
    logic signed [31:0] goal_vel_y;
    logic signed [31:0] goal_vel_z;
    logic signed [31:0] force_z;
  } item_t;

  typedef struct packed {
    logic signed [31:0] vel_out_x;
    logic signed [31:0] vel_out_y;
    logic signed [31:0] vel_out_z;
    logic signed [31:0] next_pos_x;
    logic signed [31:0] next_pos_y;
    logic signed [31:0] next_pos_z;
    logic signed [31:0] force_offset;
    logic               in_contact;
    logic               was_limited;
  } result_t;

  // Saturate to 32 bit signed
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Saturate to 48 bit signed
  function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v > 50'sh7FFFFFFFFFFF) begin
      r = 48'sh7FFFFFFFFFFF;
    end else if (v < -50'sh800000000000) begin
      r = 48'sh800000000000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

endpackage

[hdl/adsv_if.sv]
interface adsv_item_if import adsv_pkg::*; ();
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adsv_result_if import adsv_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface adsv_cfg_if import adsv_pkg::*; ();
  logic        valid;
  logic        ready;
  reg_idx_t    index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/attractor_ds_velocity_with_force_pi.sv]
// One item is worked on at a time: a new item is accepted only in idle, after the
// previous result has been loaded into the output register. The PI steps run only once
// in contact, and the scaling steps only when the velocity is scaled to the limit.
// Every step uses the shared bit-serial multiplier (32 steps), restoring divider
// (64 steps) or square root (32 steps); a stalled result holds the input off.
// Reset (rst, synchronous): clears registers, contact latch, integral, PI offset
// and the sequencer; the block is ready in the first cycle after reset.
`include "attractor_ds_velocity_with_force_pi_defines.svh"

module attractor_ds_velocity_with_force_pi import adsv_pkg::*; (
  input logic          clk,
  input logic          rst,
  adsv_cfg_if.sink     cfg,
  adsv_item_if.sink    sample,
  adsv_result_if.source result
);

  // Configuration registers
  logic [30:0]        gain, limit;
  logic signed [31:0] off_x, off_y, off_z, kp, ki, target;

  // Item and step state
  item_t              item;
  logic signed [47:0] integ;
  logic               latch;
  logic signed [31:0] pioff, up;
  logic signed [31:0] vel [3];
  logic signed [31:0] npos [3];
  logic [1:0]         k;
  logic [63:0]        ss;
  logic [32:0]        root_n;
  logic               limited;
  state_t             state, state_next;

  // Serial units
  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [79:0]        acc;
  logic [31:0]        ma;
  logic [47:0]        mb;
  logic               mneg;
  logic [63:0]        dq;
  logic [32:0]        drem, dvs;
  logic [63:0]        rx, rr, rbit;

  // Result register
  result_t            res;
  logic               res_valid;

  // Operand selection
  op_t                op;
  logic [31:0]        opa;
  logic [47:0]        opb;
  logic               opneg;
  logic [63:0]        opn;
  logic [32:0]        opd;
  logic [CNT_W-1:0]   steps;
  logic               launch, fin, take;

  logic signed [31:0] pos_k, goal_k, gv_k, off_k, vel_k;
  logic signed [32:0] e_x, e_y, e_z, e_k, err;
  logic [31:0]        e_mag, vel_mag, kp_mag, ki_mag;
  logic [32:0]        err_mag;
  logic [47:0]        integ_mag;
  logic signed [33:0] d_k;
  logic [33:0]        d_mag;
  logic               near_all, contact_new;
  logic [63:0]        ss_add;
  logic signed [80:0] prod_s, prod_rnd;
  logic signed [64:0] q16;
  logic signed [34:0] di;
  logic signed [31:0] ui_sat, ui_c, np_r;
  logic signed [32:0] cmd;
  logic signed [31:0] cmd_c;
  logic [48:0]        msum;
  logic [33:0]        rem_sh;
  logic               div_ge;
  logic [63:0]        rt;

  assign cfg.ready    = 1'b1;
  assign sample.ready = (state == ST_IDLE);
  assign take         = sample.valid && (state == ST_IDLE);
  assign result.valid = res_valid;
  assign result.data  = res;

  // Per-axis selection
  always_comb begin
    unique case (k)
      2'd0: begin
        pos_k = item.pos_x; goal_k = item.goal_x; gv_k = item.goal_vel_x;
        off_k = off_x; e_k = e_x;
      end
      2'd1: begin
        pos_k = item.pos_y; goal_k = item.goal_y; gv_k = item.goal_vel_y;
        off_k = off_y; e_k = e_y;
      end
      default: begin
        pos_k = item.pos_z; goal_k = item.goal_z; gv_k = item.goal_vel_z;
        off_k = off_z; e_k = e_z;
      end
    endcase
  end

  assign vel_k = (k == 2'd0) ? vel[0] : ((k == 2'd1) ? vel[1] : vel[2]);

  // Errors and magnitudes
  assign e_x   = 33'(item.pos_x) - 33'(item.goal_x);
  assign e_y   = 33'(item.pos_y) - 33'(item.goal_y);
  assign e_z   = 33'(item.pos_z) - 33'(item.goal_z);
  assign e_mag = e_k[32] ? 32'(-e_k) : 32'(e_k);
  assign near_all = (e_x > -33'sd1311) && (e_x < 33'sd1311) &&
                    (e_y > -33'sd1311) && (e_y < 33'sd1311) &&
                    (e_z > -33'sd1311) && (e_z < 33'sd1311);
  assign err       = 33'(item.force_z) - 33'(target);
  assign err_mag   = err[32] ? 33'(-err) : 33'(err);
  assign kp_mag    = kp[31] ? 32'(-kp) : 32'(kp);
  assign ki_mag    = ki[31] ? 32'(-ki) : 32'(ki);
  assign integ_mag = integ[47] ? 48'(-integ) : 48'(integ);
  assign vel_mag   = vel_k[31] ? 32'(-vel_k) : 32'(vel_k);
  assign d_k       = 34'(pos_k) - 34'(goal_k) - 34'(off_k) -
                     ((k == 2'd2) ? 34'(pioff) : 34'sd0);
  assign d_mag     = d_k[33] ? 34'(-d_k) : 34'(d_k);

  // Product forms: full signed and Q16.16 rounded
  assign prod_s   = mneg ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
  assign prod_rnd = prod_s + 81'sd32768;
  assign q16      = prod_rnd[80:16];
  assign ss_add   = ss + acc[63:0];
  assign contact_new = latch || (near_all && (ss_add < 64'(CONTACT_TH_SQ)));

  // PI terms
  assign di     = err[32] ? -$signed({1'b0, dq[33:0]}) : $signed({1'b0, dq[33:0]});
  assign ui_sat = sat32(66'(q16));
  assign ui_c   = (ui_sat < LOW_CLAMP) ? LOW_CLAMP : ui_sat;
  assign cmd    = 33'(ui_c) + 33'(up);
  assign cmd_c  = (cmd < 33'(LOW_CLAMP)) ? LOW_CLAMP :
                  ((cmd > 33'sd2147483647) ? 32'sh7FFFFFFF : cmd[31:0]);
  assign np_r   = vel_k[31] ? -$signed(dq[31:0]) : $signed(dq[31:0]);

  // Unit step logic
  assign msum        = {1'b0, acc[79:32]} + (ma[0] ? {1'b0, mb} : 49'd0);
  assign rem_sh      = {drem, dq[63]};
  assign div_ge      = (rem_sh >= {1'b0, dvs});
  assign rt          = rr + rbit;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (take) state_next = PI_ENABLED ? ST_SQ_E : ST_V_MUL;
      ST_SQ_E:   if (fin && k == 2'd2) state_next = contact_new ? ST_PI_INT : ST_V_MUL;
      ST_PI_INT: if (fin) state_next = ST_PI_P;
      ST_PI_P:   if (fin) state_next = ST_PI_I;
      ST_PI_I:   if (fin) state_next = ST_V_MUL;
      ST_V_MUL:  if (fin) state_next = ST_V_SQ;
      ST_V_SQ:   if (fin) state_next = (k == 2'd2) ? ST_LIM_SQ : ST_V_MUL;
      ST_LIM_SQ: if (fin) state_next = (ss > {2'b00, acc[61:0]}) ? ST_ROOT : ST_NP_DIV;
      ST_ROOT:   if (fin) state_next = ST_SC_MUL;
      ST_SC_MUL: if (fin) state_next = ST_SC_DIV;
      ST_SC_DIV: if (fin) state_next = (k == 2'd2) ? ST_NP_DIV : ST_SC_MUL;
      ST_NP_DIV: if (fin && k == 2'd2) state_next = ST_DONE;
      ST_DONE:   if (!res_valid || result.ready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Unit operands per state
  always_comb begin
    op = OP_NONE; opa = '0; opb = '0; opneg = 1'b0; opn = '0; opd = '0; steps = '0;
    unique case (state)
      ST_SQ_E: begin
        op = OP_MUL; opa = e_mag; opb = 48'(e_mag);
      end
      ST_PI_INT: begin
        op = OP_DIV; opn = 64'(err_mag) + 64'(LOOP_RATE_HZ / 2); opd = 33'(LOOP_RATE_HZ);
      end
      ST_PI_P: begin
        op = OP_MUL; opa = kp_mag; opb = 48'(err_mag); opneg = kp[31] ^ err[32];
      end
      ST_PI_I: begin
        op = OP_MUL; opa = ki_mag; opb = integ_mag; opneg = ki[31] ^ integ[47];
      end
      ST_V_MUL: begin
        op = OP_MUL; opa = {1'b0, gain}; opb = 48'(d_mag); opneg = d_k[33];
      end
      ST_V_SQ: begin
        op = OP_MUL; opa = vel_mag; opb = 48'(vel_mag);
      end
      ST_LIM_SQ: begin
        op = OP_MUL; opa = {1'b0, limit}; opb = 48'(limit);
      end
      ST_ROOT: begin
        op = OP_ROOT;
      end
      ST_SC_MUL: begin
        op = OP_MUL; opa = vel_mag; opb = 48'(limit); opneg = vel_k[31];
      end
      ST_SC_DIV: begin
        op = OP_DIV; opn = acc[63:0]; opd = root_n;
      end
      ST_NP_DIV: begin
        op = OP_DIV; opn = 64'(vel_mag) + 64'(LOOP_RATE_HZ / 2); opd = 33'(LOOP_RATE_HZ);
      end
      default: op = OP_NONE;
    endcase
    unique case (op)
      OP_MUL:  steps = CNT_W'(MUL_STEPS);
      OP_DIV:  steps = CNT_W'(DIV_STEPS);
      OP_ROOT: steps = CNT_W'(ROOT_STEPS);
      default: steps = '0;
    endcase
  end

  assign launch = (op != OP_NONE) && !busy;
  assign fin    = busy && (cnt == '0);

  // Control, configuration and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy <= 1'b0;
      cnt <= '0;
      k <= '0;
      latch <= 1'b0;
      integ <= '0;
      pioff <= '0;
      res_valid <= 1'b0;
      gain <= '0; limit <= '0;
      off_x <= '0; off_y <= '0; off_z <= '0;
      kp <= '0; ki <= '0; target <= '0;
    end else begin
      state <= state_next;
      // run the shared unit
      if (launch) begin
        busy <= 1'b1;
        cnt <= steps;
      end else if (fin) begin
        busy <= 1'b0;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
      end
      // advance the axis index at the end of each per-axis step
      if (take) begin
        k <= '0;
      end else if (fin && (state == ST_SQ_E || state == ST_V_SQ ||
                           state == ST_SC_DIV || state == ST_NP_DIV)) begin
        k <= (k == 2'd2) ? 2'd0 : k + 2'd1;
      end
      // contact and PI state
      if (fin && state == ST_SQ_E && k == 2'd2) latch <= contact_new;
      if (fin && state == ST_PI_INT) integ <= sat48(50'(integ) + 50'(di));
      if (fin && state == ST_PI_I) pioff <= cmd_c;
      // output register: load on leaving done, drop on transfer
      if (state == ST_DONE && (!res_valid || result.ready)) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      // configuration writes
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_GAIN:   gain <= cfg.data[30:0];
          REG_LIMIT:  limit <= cfg.data[30:0];
          REG_OFF_X:  off_x <= cfg.data;
          REG_OFF_Y:  off_y <= cfg.data;
          REG_OFF_Z:  off_z <= cfg.data;
          REG_KP:     kp <= cfg.data;
          REG_KI:     ki <= cfg.data;
          REG_TARGET: target <= cfg.data;
          default:    gain <= gain;
        endcase
      end
    end
  end

  // Serial unit datapath
  always_ff @(posedge clk) begin
    if (launch) begin
      unique case (op)
        OP_MUL: begin
          acc <= '0; ma <= opa; mb <= opb; mneg <= opneg;
        end
        OP_DIV: begin
          dq <= opn; drem <= '0; dvs <= opd;
        end
        OP_ROOT: begin
          rx <= ss; rr <= '0; rbit <= {2'b01, 62'd0};
        end
        default: acc <= acc;
      endcase
    end else if (busy && cnt != '0) begin
      unique case (op)
        OP_MUL: begin
          acc <= {msum, acc[31:1]};
          ma <= ma >> 1;
        end
        OP_DIV: begin
          drem <= div_ge ? 33'(rem_sh - {1'b0, dvs}) : rem_sh[32:0];
          dq <= {dq[62:0], div_ge};
        end
        OP_ROOT: begin
          if (rx >= rt) begin
            rx <= rx - rt;
            rr <= (rr >> 1) + rbit;
          end else begin
            rr <= rr >> 1;
          end
          rbit <= rbit >> 2;
        end
        default: acc <= acc;
      endcase
    end
  end

  // Item payload and per-step results
  always_ff @(posedge clk) begin
    if (take) begin
      item <= sample.data;
      ss <= '0;
    end
    if (fin) begin
      unique case (state)
        ST_SQ_E:   ss <= (k == 2'd2) ? 64'd0 : ss_add;
        ST_PI_P:   up <= sat32(66'(q16));
        ST_V_MUL:  vel[k] <= sat32(66'(gv_k) - 66'(q16));
        ST_V_SQ:   ss <= ss_add;
        ST_LIM_SQ: limited <= (ss > {2'b00, acc[61:0]});
        ST_ROOT:   root_n <= rr[32:0];
        ST_SC_DIV: vel[k] <= mneg ? -$signed(dq[31:0]) : $signed(dq[31:0]);
        ST_NP_DIV: npos[k] <= sat32(66'(pos_k) + 66'(np_r));
        default:   root_n <= root_n;
      endcase
    end
    if (state == ST_DONE && (!res_valid || result.ready)) begin
      res.vel_out_x    <= vel[0];
      res.vel_out_y    <= vel[1];
      res.vel_out_z    <= vel[2];
      res.next_pos_x   <= npos[0];
      res.next_pos_y   <= npos[1];
      res.next_pos_z   <= npos[2];
      res.force_offset <= pioff;
      res.in_contact   <= latch;
      res.was_limited  <= limited;
    end
  end

  // Checks
  `ADSV_ASSERT_NEXT(a_latch_holds, latch, latch)
  `ADSV_ASSERT_IMPL(a_offset_floor, 1'b1, pioff >= LOW_CLAMP)
  `ADSV_ASSERT_IMPL(a_offset_idle, !latch, pioff == 32'sd0)
  `ADSV_ASSERT_IMPL(a_unit_in_op, busy, state != ST_IDLE && state != ST_DONE)
  `ADSV_ASSERT_IMPL(a_load_from_done, $rose(res_valid), $past(state) == ST_DONE)

endmodule
